/* sv/jbt_pkg.sv */
package jbt_pkg;

    localparam int KindW = 5;
    localparam int CodeW = 3;
    localparam int MaxRes = 3;

    localparam logic [KindW-1:0] K_STR   = 5'd0;
    localparam logic [KindW-1:0] K_BARE  = 5'd1;
    localparam logic [KindW-1:0] K_LBRC  = 5'd2;
    localparam logic [KindW-1:0] K_RBRC  = 5'd3;
    localparam logic [KindW-1:0] K_LBRK  = 5'd4;
    localparam logic [KindW-1:0] K_RBRK  = 5'd5;
    localparam logic [KindW-1:0] K_COLON = 5'd6;
    localparam logic [KindW-1:0] K_COMMA = 5'd7;
    localparam logic [KindW-1:0] K_NULL  = 5'd8;
    localparam logic [KindW-1:0] K_TRUE  = 5'd9;
    localparam logic [KindW-1:0] K_FALSE = 5'd10;
    localparam logic [KindW-1:0] K_NAT   = 5'd11;
    localparam logic [KindW-1:0] K_SEND  = 5'd14;
    localparam logic [KindW-1:0] K_DONE  = 5'd15;
    localparam logic [KindW-1:0] K_ERR   = 5'd16;

    localparam logic [CodeW-1:0] E_CHAR  = 3'd1;
    localparam logic [CodeW-1:0] E_DELIM = 3'd2;
    localparam logic [CodeW-1:0] E_BARE  = 3'd3;
    localparam logic [CodeW-1:0] E_ESC   = 3'd4;
    localparam logic [CodeW-1:0] E_HEX   = 3'd5;
    localparam logic [CodeW-1:0] E_SURR  = 3'd6;
    localparam logic [CodeW-1:0] E_OPEN  = 3'd7;

    typedef struct packed {
        logic [KindW-1:0] kind;
        logic [7:0]       data;
        logic             esc;
        logic [CodeW-1:0] code;
    } res_t;

    typedef struct packed {
        logic [1:0] n;
        res_t [MaxRes-1:0] r;
    } res_set_t;

endpackage

/* sv/jbt_core.sv */
module jbt_core
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [7:0]       c,
    input  logic             last,
    output jbt_pkg::res_set_t res
);
    import jbt_pkg::*;

    typedef enum logic [1:0] {M_GEN, M_STR, M_ESC, M_UNI} mode_t;

    mode_t mode_reg, mode_next;
    logic [1:0] hex_reg, hex_next;
    logic [7:0] hub_reg, hub_next;
    logic [3:0] ns_reg, ns_next, ks_reg, ks_next;
    logic [1:0] nt_reg, nt_next;
    logic pend_reg, pend_next, closed_reg, closed_next;
    logic esc_reg, esc_next, halt_reg, halt_next;

    logic [CodeW-1:0] err;
    logic isd, isx, isb, ishx;
    logic [3:0] hv;
    logic [7:0] ed;
    logic eok;
    logic [7:0] kwe;
    logic [KindW-1:0] ck;
    logic cok;

    always_comb
    begin
        isd = (c >= "0") && (c <= "9");
        isx = (c == "e") || (c == "E");
        isb = isd || (c == "+") || (c == "-") || (c == ".") || (c == "E") || (c == "a")
            || (c == "e") || (c == "f") || (c == "l") || (c == "n") || (c == "r")
            || (c == "s") || (c == "t") || (c == "u");
        ishx = 1'b1;
        hv = 4'd0;
        if (isd) hv = c[3:0];
        else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) hv = c[3:0] + 4'd9;
        else ishx = 1'b0;
        eok = 1'b1;
        case (c)
            "\"": ed = 8'h22;
            "\\": ed = 8'h5C;
            "/":  ed = 8'h2F;
            "b":  ed = 8'h08;
            "f":  ed = 8'h0C;
            "n":  ed = 8'h0A;
            "r":  ed = 8'h0D;
            "t":  ed = 8'h09;
            default:
            begin
                ed = 8'h00;
                eok = 1'b0;
            end
        endcase
        case (ks_reg)
            4'd1: kwe = "u";
            4'd2, 4'd3, 4'd10: kwe = "l";
            4'd5: kwe = "r";
            4'd6: kwe = "u";
            4'd7, 4'd12: kwe = "e";
            4'd9: kwe = "a";
            4'd11: kwe = "s";
            default: kwe = 8'h00;
        endcase
        cok = 1'b1;
        ck = K_NULL;
        if (ks_reg == 4'd4) ck = K_NULL;
        else if (ks_reg == 4'd8) ck = K_TRUE;
        else if (ks_reg == 4'd13) ck = K_FALSE;
        else if (ns_reg == 4'd2 || ns_reg == 4'd3 || ns_reg == 4'd6 || ns_reg == 4'd8)
            ck = K_NAT + KindW'(nt_reg);
        else cok = 1'b0;
    end

    always_comb
    begin
        mode_next = mode_reg;
        hex_next = hex_reg;
        hub_next = hub_reg;
        ns_next = ns_reg;
        ks_next = ks_reg;
        nt_next = nt_reg;
        pend_next = pend_reg;
        closed_next = closed_reg;
        esc_next = esc_reg;
        halt_next = halt_reg;
        err = '0;
        res = '0;
        if (!halt_reg)
        begin
            case (mode_reg)
                M_GEN:
                begin
                    if (c == 8'h09 || c == 8'h0A || c == 8'h0D || c == 8'h20)
                    begin
                        if (pend_reg) closed_next = 1'b1;
                    end
                    else if (isb)
                    begin
                        if (closed_reg) err = E_BARE;
                        else
                        begin
                            res.r[0] = '{K_BARE, c, 1'b0, '0};
                            res.n = 2'd1;
                            pend_next = 1'b1;
                            ns_next = 4'd9;
                            case (ns_reg)
                                4'd0:
                                    if (c == "-") begin nt_next = 2'd1; ns_next = 4'd1; end
                                    else if (c == "0") begin nt_next = 2'd0; ns_next = 4'd2; end
                                    else if (isd) begin nt_next = 2'd0; ns_next = 4'd3; end
                                4'd1: ns_next = (c == "0") ? 4'd2 : (isd ? 4'd3 : 4'd9);
                                4'd2:
                                begin
                                    nt_next = 2'd2;
                                    ns_next = (c == ".") ? 4'd4 : (isx ? 4'd5 : 4'd9);
                                end
                                4'd3:
                                    if (isd) ns_next = 4'd3;
                                    else if (c == ".") begin nt_next = 2'd2; ns_next = 4'd4; end
                                    else if (isx) begin nt_next = 2'd2; ns_next = 4'd5; end
                                4'd4: ns_next = isd ? 4'd6 : 4'd9;
                                4'd6: ns_next = isd ? 4'd6 : (isx ? 4'd5 : 4'd9);
                                4'd5: ns_next = (c == "+" || c == "-") ? 4'd7
                                              : (isd ? 4'd8 : 4'd9);
                                4'd7, 4'd8: ns_next = isd ? 4'd8 : 4'd9;
                                default: ns_next = 4'd9;
                            endcase
                            if (ks_reg == 4'd0)
                                ks_next = (c == "n") ? 4'd1 : (c == "t") ? 4'd5
                                        : (c == "f") ? 4'd9 : 4'd15;
                            else if (kwe != 8'h00 && c == kwe) ks_next = ks_reg + 4'd1;
                            else ks_next = 4'd15;
                        end
                    end
                    else if (c == "{" || c == "[" || c == ":" || c == "\"")
                    begin
                        if (pend_reg) err = E_DELIM;
                        else if (c == "\"")
                        begin
                            mode_next = M_STR;
                            esc_next = 1'b0;
                        end
                        else
                        begin
                            res.r[0].kind = (c == "{") ? K_LBRC : (c == "[") ? K_LBRK : K_COLON;
                            res.n = 2'd1;
                        end
                    end
                    else if (c == "}" || c == "]" || c == ",")
                    begin
                        if (pend_reg && !cok) err = E_BARE;
                        else
                        begin
                            if (pend_reg)
                            begin
                                res.r[0].kind = ck;
                                res.n = 2'd1;
                                ns_next = '0;
                                nt_next = '0;
                                ks_next = '0;
                                pend_next = 1'b0;
                                closed_next = 1'b0;
                            end
                            res.r[res.n].kind = (c == "}") ? K_RBRC
                                              : (c == "]") ? K_RBRK : K_COMMA;
                            res.n = res.n + 2'd1;
                        end
                    end
                    else err = E_CHAR;
                end
                M_STR:
                begin
                    if (c == "\"")
                    begin
                        res.r[0] = '{K_SEND, 8'h00, esc_reg, '0};
                        res.n = 2'd1;
                        mode_next = M_GEN;
                    end
                    else if (c == "\\")
                    begin
                        esc_next = 1'b1;
                        mode_next = M_ESC;
                    end
                    else
                    begin
                        res.r[0] = '{K_STR, c, 1'b0, '0};
                        res.n = 2'd1;
                    end
                end
                M_ESC:
                begin
                    if (eok)
                    begin
                        res.r[0] = '{K_STR, ed, 1'b0, '0};
                        res.n = 2'd1;
                        mode_next = M_STR;
                    end
                    else if (c == "u")
                    begin
                        mode_next = M_UNI;
                        hex_next = '0;
                    end
                    else err = E_ESC;
                end
                default:
                begin
                    if (!ishx) err = E_HEX;
                    else
                        case (hex_reg)
                            2'd0:
                            begin
                                hub_next = {hv, 4'h0};
                                hex_next = 2'd1;
                            end
                            2'd1:
                            begin
                                hub_next = {hub_reg[7:4], hv};
                                res.r[0] = '{K_STR, {hub_reg[7:4], hv}, 1'b0, '0};
                                res.n = 2'd1;
                                hex_next = 2'd2;
                            end
                            2'd2:
                            begin
                                hub_next = {3'b000, (hub_reg >= 8'hD8 && hub_reg <= 8'hDF), hv};
                                hex_next = 2'd3;
                            end
                            default:
                                if (hub_reg[4]) err = E_SURR;
                                else
                                begin
                                    res.r[0] = '{K_STR, {hub_reg[3:0], hv}, 1'b0, '0};
                                    res.n = 2'd1;
                                    mode_next = M_STR;
                                    hex_next = '0;
                                end
                        endcase
                end
            endcase
            if (err != '0)
            begin
                res.r[res.n] = '{K_ERR, 8'h00, 1'b0, err};
                res.n = res.n + 2'd1;
                halt_next = 1'b1;
            end
            else if (last)
            begin
                if (mode_next != M_GEN || pend_next)
                    res.r[res.n] = '{K_ERR, 8'h00, 1'b0, E_OPEN};
                else
                    res.r[res.n] = '{K_DONE, 8'h00, 1'b0, '0};
                res.n = res.n + 2'd1;
            end
        end
        if (last)
        begin
            mode_next = M_GEN;
            hex_next = '0;
            hub_next = '0;
            ns_next = '0;
            ks_next = '0;
            nt_next = '0;
            pend_next = 1'b0;
            closed_next = 1'b0;
            esc_next = 1'b0;
            halt_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_GEN;
            hex_reg <= '0;
            hub_reg <= '0;
            ns_reg <= '0;
            ks_reg <= '0;
            nt_reg <= '0;
            pend_reg <= 1'b0;
            closed_reg <= 1'b0;
            esc_reg <= 1'b0;
            halt_reg <= 1'b0;
        end
        else if (step)
        begin
            mode_reg <= mode_next;
            hex_reg <= hex_next;
            hub_reg <= hub_next;
            ns_reg <= ns_next;
            ks_reg <= ks_next;
            nt_reg <= nt_next;
            pend_reg <= pend_next;
            closed_reg <= closed_next;
            esc_reg <= esc_next;
            halt_reg <= halt_next;
        end
    end

endmodule

/* sv/json_byte_tokenizer_unit.sv */
// Results: the results of an accepted byte are captured in the result register when it is accepted.
// Throughput: one input byte per cycle while each byte yields at most one result and m_axis_tready is high;
// a byte with more results holds input until its last beat pops, one beat per cycle while m_axis_tready is high.
// Reset: rst_n is asynchronous and active low; it returns the lexer to its general
// state and empties the result register.
module json_byte_tokenizer_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // text_byte
    input  logic        s_axis_tlast,  // doc_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // event_kind, data_byte, had_escape, error_code, zeros
    output logic        m_axis_tlast   // run_last
);
    import jbt_pkg::*;

    res_set_t res;
    res_t [MaxRes-1:0] buf_reg;
    logic [1:0] cnt_reg, idx_reg;
    logic step, pop;

    assign pop = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (cnt_reg == 2'd0) || (pop && cnt_reg == idx_reg + 2'd1);
    assign step = s_axis_tvalid && s_axis_tready;

    jbt_core u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .c     (s_axis_tdata),
        .last  (s_axis_tlast),
        .res   (res)
    );

    assign m_axis_tvalid = cnt_reg != 2'd0;
    assign m_axis_tdata = {7'b0000000, buf_reg[idx_reg].code, buf_reg[idx_reg].esc,
                           buf_reg[idx_reg].data, buf_reg[idx_reg].kind};
    assign m_axis_tlast = (idx_reg + 2'd1) == cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end
        else if (step)
        begin
            cnt_reg <= res.n;
            idx_reg <= '0;
        end
        else if (pop)
        begin
            if (m_axis_tlast)
            begin
                cnt_reg <= '0;
                idx_reg <= '0;
            end
            else idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step) buf_reg <= res.r;
    end

endmodule
